### rtl/iss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

    // Field widths
    localparam int MV_W       = 15;
    localparam int CODE_W     = 10;
    localparam int BUS_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Divide by 100: (v * 5243) >> 19 is exact for every 15-bit v
    localparam int                MUL100_W   = 13;
    localparam logic [MUL100_W-1:0] DIV100_MUL = 13'd5243;
    localparam int                DIV100_SH  = 19;
    localparam int                TENTHS_W   = MV_W + MUL100_W - DIV100_SH;
    localparam logic [BUS_W-1:0]  BUS_MAX    = 8'd255;

    typedef logic [MV_W-1:0]      mv_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes
    localparam cfg_idx_t REG_FULL_SCALE = 8'd0;
    localparam cfg_idx_t REG_MIN_VOLT   = 8'd1;
    localparam cfg_idx_t REG_DEADBAND   = 8'd2;
    localparam cfg_idx_t REG_TRIP       = 8'd3;

    // Register reset values
    localparam mv_t   RST_FULL_SCALE = 15'd12000;
    localparam mv_t   RST_MIN_VOLT   = 15'd200;
    localparam mv_t   RST_DEADBAND   = 15'd100;
    localparam code_t RST_TRIP       = 10'd1023;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT,
        PH_FAULT
    } phase_t;

    typedef struct packed {
        mv_t   full_scale_mv;
        mv_t   min_volt_mv;
        mv_t   deadband_mv;
        code_t current_trip_code;
    } iss_cfg_t;

    // Per-sample control bits carried down the scaling pipe
    typedef struct packed {
        logic dir_en;
        logic dir_val;
        logic trip;
        logic ack;
    } iss_flags_t;

    // Scaled sample handed to the supervisor
    typedef struct packed {
        iss_flags_t       flags;
        mv_t              volt_mv;
        logic [BUS_W-1:0] tenths;
    } iss_item_t;

endpackage

`default_nettype wire

### rtl/inverter_setpoint_supervisor_core.sv
// Inverter setpoint supervisor. Each input transaction is one sampled tick of
// the direction switches, speed pot, three phase-current codes and the partner
// ACK line; each produces exactly one result transaction with the direction,
// READY, bus byte (tenths of a volt) and latched overcurrent fault. A new tick
// is accepted every cycle while the result channel is not stalled. Each tick
// passes through the five-register scaling pipe (sampled inputs, pot times
// full scale, reciprocal multiply for the divide by the ADC full code, quotient
// correction and clamp, divide by 100) and then the register that holds the
// supervisor state and outputs. With the result channel stalled the pipe fills
// and then holds off the input channel. Configuration writes are always
// accepted and must be issued only while no transactions are in flight.
`timescale 1ns / 1ps
`default_nettype none

module inverter_setpoint_supervisor_core #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Sample channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_switch_forward,
    input  wire logic                          s_switch_reverse,
    input  wire logic [iss_pkg::CODE_W-1:0]    s_pot_code,
    input  wire logic [iss_pkg::CODE_W-1:0]    s_current_a_code,
    input  wire logic [iss_pkg::CODE_W-1:0]    s_current_b_code,
    input  wire logic [iss_pkg::CODE_W-1:0]    s_current_c_code,
    input  wire logic                          s_ack_level,
    // Result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_direction_out,
    output logic                               m_ready_out,
    output logic [iss_pkg::BUS_W-1:0]          m_bus_byte,
    output logic                               m_fault_out,
    // Configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [iss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import iss_pkg::*;

    iss_cfg_t  cfg;
    iss_item_t item;
    logic      item_valid;
    logic      item_ready;

    iss_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iss_scale_pipe #(
        .ADC_BITS (ADC_BITS)
    ) u_pipe (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_switch_forward (s_switch_forward),
        .s_switch_reverse (s_switch_reverse),
        .s_pot_code       (s_pot_code),
        .s_current_a_code (s_current_a_code),
        .s_current_b_code (s_current_b_code),
        .s_current_c_code (s_current_c_code),
        .s_ack_level      (s_ack_level),
        .cfg              (cfg),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item)
    );

    iss_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .deadband_mv     (cfg.deadband_mv),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_direction_out (m_direction_out),
        .m_ready_out     (m_ready_out),
        .m_bus_byte      (m_bus_byte),
        .m_fault_out     (m_fault_out)
    );

endmodule

`default_nettype wire

### rtl/iss_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module iss_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [iss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iss_pkg::CFG_DATA_W-1:0] cfg_data,
    output iss_pkg::iss_cfg_t                 cfg
);
    import iss_pkg::*;

    iss_cfg_t cfg_reg;
    iss_cfg_t cfg_next;

    // Writes are always accepted
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FULL_SCALE: cfg_next.full_scale_mv     = cfg_data[MV_W-1:0];
                REG_MIN_VOLT:   cfg_next.min_volt_mv       = cfg_data[MV_W-1:0];
                REG_DEADBAND:   cfg_next.deadband_mv       = cfg_data[MV_W-1:0];
                REG_TRIP:       cfg_next.current_trip_code = cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_scale_mv     <= RST_FULL_SCALE;
            cfg_reg.min_volt_mv       <= RST_MIN_VOLT;
            cfg_reg.deadband_mv       <= RST_DEADBAND;
            cfg_reg.current_trip_code <= RST_TRIP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/iss_scale_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module iss_scale_pipe #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_switch_forward,
    input  wire logic                    s_switch_reverse,
    input  wire logic [iss_pkg::CODE_W-1:0] s_pot_code,
    input  wire logic [iss_pkg::CODE_W-1:0] s_current_a_code,
    input  wire logic [iss_pkg::CODE_W-1:0] s_current_b_code,
    input  wire logic [iss_pkg::CODE_W-1:0] s_current_c_code,
    input  wire logic                    s_ack_level,
    input  wire iss_pkg::iss_cfg_t       cfg,
    output logic                         item_valid,
    input  wire logic                    item_ready,
    output iss_pkg::iss_item_t           item
);
    import iss_pkg::*;

    localparam int STAGES    = 5;
    localparam int ADC_FULL  = (1 << ADC_BITS) - 1;
    localparam int POT_CMP_W = ((ADC_BITS > CODE_W) ? ADC_BITS : CODE_W) + 1;
    localparam logic [POT_CMP_W-1:0] POT_LIMIT = POT_CMP_W'(ADC_FULL);
    localparam int PROD_W    = ADC_BITS + MV_W;
    localparam int RECIP_W   = MV_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((longint'(1) << PROD_W) / ADC_FULL);
    localparam int EST_W     = PROD_W + RECIP_W;
    localparam int REM_W     = PROD_W + 1;
    localparam logic [REM_W-1:0] DIVISOR = REM_W'(ADC_FULL);
    localparam int T_PROD_W  = MV_W + MUL100_W;

    // Stage valids and per-stage ready
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] rdy;
    logic [STAGES-1:0] load;

    // Stage 0: sampled inputs
    logic  s0_fwd_reg, s0_rev_reg, s0_ack_reg;
    code_t s0_pot_reg, s0_ia_reg, s0_ib_reg, s0_ic_reg;
    // Stage 1: pot times full scale
    logic [PROD_W-1:0] s1_prod_reg;
    iss_flags_t        s1_flags_reg;
    // Stage 2: quotient estimate
    logic [PROD_W-1:0]  s2_prod_reg;
    logic [RECIP_W-1:0] s2_est_reg;
    iss_flags_t         s2_flags_reg;
    // Stage 3: setpoint
    mv_t        s3_volt_reg;
    iss_flags_t s3_flags_reg;
    // Stage 4: setpoint and bus value
    iss_item_t  s4_item_reg;

    logic [POT_CMP_W-1:0] pot_wide;
    logic [ADC_BITS-1:0]  pot_sat;
    logic [PROD_W-1:0]    prod_a;
    iss_flags_t           flags_a;
    logic [EST_W-1:0]     est_full;
    logic [REM_W-1:0]     est_times_d;
    logic [REM_W-1:0]     rem_c;
    mv_t                  quo_c;
    mv_t                  scaled_c;
    mv_t                  volt_c;
    logic [T_PROD_W-1:0]  tenths_full;
    logic [TENTHS_W-1:0]  tenths_q;
    logic [BUS_W-1:0]     tenths_sat;

    // Ready chain: a stage takes new data when empty or when it drains
    always_comb begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || item_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        load[0]     = s_valid && rdy[0];
        vld_next[0] = rdy[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            load[i]     = vld_reg[i-1] && rdy[i];
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign s_ready    = rdy[0];
    assign item_valid = vld_reg[STAGES-1];
    assign item       = s4_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // A: saturate pot, multiply by full scale, check trip
    always_comb begin
        pot_wide = {{(POT_CMP_W-CODE_W){1'b0}}, s0_pot_reg};
        pot_sat  = (pot_wide > POT_LIMIT) ? POT_LIMIT[ADC_BITS-1:0]
                                          : pot_wide[ADC_BITS-1:0];
        prod_a   = {{MV_W{1'b0}}, pot_sat} * {{ADC_BITS{1'b0}}, cfg.full_scale_mv};
        flags_a.dir_en  = s0_fwd_reg || s0_rev_reg;
        flags_a.dir_val = s0_fwd_reg;
        flags_a.trip    = (s0_ia_reg > cfg.current_trip_code) ||
                          (s0_ib_reg > cfg.current_trip_code) ||
                          (s0_ic_reg > cfg.current_trip_code);
        flags_a.ack     = s0_ack_reg;
    end

    // B: reciprocal multiply, estimate is exact or one low
    assign est_full = {{RECIP_W{1'b0}}, s1_prod_reg} * {{PROD_W{1'b0}}, RECIP};

    // C: correct the estimate, clamp to minimum, zero with no switch
    always_comb begin
        est_times_d = {s2_est_reg, {ADC_BITS{1'b0}}} - {{ADC_BITS{1'b0}}, s2_est_reg};
        rem_c       = {1'b0, s2_prod_reg} - est_times_d;
        quo_c       = s2_est_reg[MV_W-1:0] + MV_W'(rem_c >= DIVISOR);
        scaled_c    = (quo_c < cfg.min_volt_mv) ? cfg.min_volt_mv : quo_c;
        volt_c      = s2_flags_reg.dir_en ? scaled_c : '0;
    end

    // D: tenths of a volt, saturated to the bus width
    always_comb begin
        tenths_full = {{MUL100_W{1'b0}}, s3_volt_reg} * {{MV_W{1'b0}}, DIV100_MUL};
        tenths_q    = tenths_full[T_PROD_W-1:DIV100_SH];
        tenths_sat  = (tenths_q > {1'b0, BUS_MAX}) ? BUS_MAX : tenths_q[BUS_W-1:0];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            s0_fwd_reg <= s_switch_forward;
            s0_rev_reg <= s_switch_reverse;
            s0_pot_reg <= s_pot_code;
            s0_ia_reg  <= s_current_a_code;
            s0_ib_reg  <= s_current_b_code;
            s0_ic_reg  <= s_current_c_code;
            s0_ack_reg <= s_ack_level;
        end
        if (load[1]) begin
            s1_prod_reg  <= prod_a;
            s1_flags_reg <= flags_a;
        end
        if (load[2]) begin
            s2_prod_reg  <= s1_prod_reg;
            s2_est_reg   <= est_full[EST_W-1:PROD_W];
            s2_flags_reg <= s1_flags_reg;
        end
        if (load[3]) begin
            s3_volt_reg  <= volt_c;
            s3_flags_reg <= s2_flags_reg;
        end
        if (load[4]) begin
            s4_item_reg.flags   <= s3_flags_reg;
            s4_item_reg.volt_mv <= s3_volt_reg;
            s4_item_reg.tenths  <= tenths_sat;
        end
    end

endmodule

`default_nettype wire

### rtl/iss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module iss_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire iss_pkg::iss_item_t      item,
    input  wire logic [iss_pkg::MV_W-1:0] deadband_mv,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_direction_out,
    output logic                         m_ready_out,
    output logic [iss_pkg::BUS_W-1:0]    m_bus_byte,
    output logic                         m_fault_out
);
    import iss_pkg::*;

    phase_t           phase_reg, phase_next;
    logic             ack_latched_reg, ack_latched_next;
    mv_t              pending_reg, pending_next;
    mv_t              last_sent_reg, last_sent_next;
    logic             direction_reg, direction_next;
    logic [BUS_W-1:0] bus_reg, bus_next;
    logic             ready_reg, ready_next;
    logic             m_valid_reg, m_valid_next;
    logic             fire;
    mv_t              diff;

    // Result register is free or being emptied
    assign item_ready = !m_valid_reg || m_ready;
    assign fire       = item_valid && item_ready;

    assign m_valid         = m_valid_reg;
    assign m_direction_out = direction_reg;
    assign m_ready_out     = ready_reg;
    assign m_bus_byte      = bus_reg;
    assign m_fault_out     = (phase_reg == PH_FAULT);

    assign diff = (item.volt_mv > last_sent_reg) ? (item.volt_mv - last_sent_reg)
                                                 : (last_sent_reg - item.volt_mv);

    // Supervisor next state, applied once per transaction
    always_comb begin
        phase_next       = phase_reg;
        ack_latched_next = ack_latched_reg;
        pending_next     = pending_reg;
        last_sent_next   = last_sent_reg;
        direction_next   = direction_reg;
        bus_next         = bus_reg;
        ready_next       = ready_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        if (fire) begin
            m_valid_next = 1'b1;
            case (phase_reg)
                PH_IDLE: begin
                    ack_latched_next = item.flags.ack;
                    if (item.flags.dir_en) begin
                        direction_next = item.flags.dir_val;
                    end
                    pending_next = item.volt_mv;
                    if (item.flags.trip) begin
                        phase_next = PH_FAULT;
                    end else if (diff != '0 && diff >= deadband_mv) begin
                        ready_next = 1'b1;
                        bus_next   = item.tenths;
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    // Partner acknowledges by toggling its line
                    if (item.flags.ack != ack_latched_reg) begin
                        ready_next     = 1'b0;
                        last_sent_next = pending_reg;
                        phase_next     = PH_IDLE;
                    end
                end
                PH_FAULT: ;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            ack_latched_reg <= 1'b0;
            pending_reg     <= '0;
            last_sent_reg   <= '0;
            direction_reg   <= 1'b0;
            bus_reg         <= '0;
            ready_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            ack_latched_reg <= ack_latched_next;
            pending_reg     <= pending_next;
            last_sent_reg   <= last_sent_next;
            direction_reg   <= direction_next;
            bus_reg         <= bus_next;
            ready_reg       <= ready_next;
            m_valid_reg     <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### verif/setpoint_checker.sv
`timescale 1ns / 1ps

// Watches the sample, result and register channels of the setpoint supervisor.
// Keeps its own copy of the supervisor state, works out the line states that
// each accepted sample must produce, and compares them in order.
module setpoint_checker #(
    parameter int ADC_BITS = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    input  wire logic                           s_ready,
    input  wire logic                           s_switch_forward,
    input  wire logic                           s_switch_reverse,
    input  wire logic [iss_pkg::CODE_W-1:0]     s_pot_code,
    input  wire logic [iss_pkg::CODE_W-1:0]     s_current_a_code,
    input  wire logic [iss_pkg::CODE_W-1:0]     s_current_b_code,
    input  wire logic [iss_pkg::CODE_W-1:0]     s_current_c_code,
    input  wire logic                           s_ack_level,
    input  wire logic                           m_valid,
    input  wire logic                           m_ready,
    input  wire logic                           m_direction_out,
    input  wire logic                           m_ready_out,
    input  wire logic [iss_pkg::BUS_W-1:0]      m_bus_byte,
    input  wire logic                           m_fault_out,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [iss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [iss_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                  error_count,
    output int                                  pending_count
);
    import iss_pkg::*;

    localparam int unsigned ADC_FULL = (1 << ADC_BITS) - 1;

    // Output lines expected for one sample
    typedef struct packed {
        logic             dir;
        logic             rdy;
        logic [BUS_W-1:0] bus;
        logic             fault;
    } lines_t;

    lines_t line_states_due[$];

    // Register copies
    mv_t   full_scale_mv;
    mv_t   floor_mv;
    mv_t   band_mv;
    code_t trip_code;

    // Supervisor state copy
    phase_t      ph;
    logic        ack_seen;
    logic        dir_q;
    logic        rdy_q;
    logic [BUS_W-1:0] bus_q;
    logic [15:0] pending_mv;
    logic [15:0] sent_mv;

    initial error_count = 0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        $display("setpoint_checker: %0t %s got %0d want %0d", $time, what, got, want);
    endtask

    // Pot code to millivolts, floored, raised to the minimum
    function automatic logic [15:0] scaled_setpoint(input code_t pot);
        int unsigned p;
        int unsigned v;
        p = pot;
        if (p > ADC_FULL)
            p = ADC_FULL;
        v = (p * full_scale_mv) / ADC_FULL;
        if (v < floor_mv)
            v = floor_mv;
        return v[15:0];
    endfunction

    // One sampled tick through the supervisor
    task automatic step_supervisor(input logic fwd, input logic rev, input code_t pot,
                                   input code_t ia, input code_t ib, input code_t ic,
                                   input logic ack);
        logic [15:0] v;
        int unsigned diff;
        int unsigned tenths;
        if (ph == PH_WAIT) begin
            // waiting for the partner to flip ACK
            if (ack != ack_seen) begin
                rdy_q   = 1'b0;
                sent_mv = pending_mv;
                ph      = PH_IDLE;
            end
        end else if (ph != PH_FAULT) begin
            v        = '0;
            ack_seen = ack;
            if (fwd) begin
                dir_q = 1'b1;
                v     = scaled_setpoint(pot);
            end else if (rev) begin
                dir_q = 1'b0;
                v     = scaled_setpoint(pot);
            end
            pending_mv = v;
            if (ia > trip_code || ib > trip_code || ic > trip_code) begin
                ph = PH_FAULT;
            end else begin
                diff = (v > sent_mv) ? v - sent_mv : sent_mv - v;
                if (diff != 0 && diff >= band_mv) begin
                    tenths = v / 100;
                    rdy_q  = 1'b1;
                    bus_q  = (tenths > BUS_MAX) ? BUS_MAX : tenths[BUS_W-1:0];
                    ph     = PH_WAIT;
                end
            end
        end
        line_states_due.push_back(lines_t'{dir_q, rdy_q, bus_q, ph == PH_FAULT});
    endtask

    // Results are checked before the same-edge sample is predicted
    always @(posedge aclk) begin
        lines_t got;
        lines_t want;
        if (!aresetn) begin
            full_scale_mv = RST_FULL_SCALE;
            floor_mv      = RST_MIN_VOLT;
            band_mv       = RST_DEADBAND;
            trip_code     = RST_TRIP;
            ph            = PH_IDLE;
            ack_seen      = 1'b0;
            dir_q         = 1'b0;
            rdy_q         = 1'b0;
            bus_q         = '0;
            pending_mv    = '0;
            sent_mv       = '0;
            line_states_due.delete();
            pending_count <= 0;
        end else begin
            // register write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FULL_SCALE: full_scale_mv = cfg_data[MV_W-1:0];
                    REG_MIN_VOLT:   floor_mv      = cfg_data[MV_W-1:0];
                    REG_DEADBAND:   band_mv       = cfg_data[MV_W-1:0];
                    REG_TRIP:       trip_code     = cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            // result transaction
            if (m_valid && m_ready) begin
                got = '{m_direction_out, m_ready_out, m_bus_byte, m_fault_out};
                if (line_states_due.size() == 0) begin
                    report_mismatch("result with nothing due, bus", got.bus, 0);
                end else begin
                    want = line_states_due.pop_front();
                    if (got.dir !== want.dir)
                        report_mismatch("direction_out", got.dir, want.dir);
                    if (got.rdy !== want.rdy)
                        report_mismatch("ready_out", got.rdy, want.rdy);
                    if (got.bus !== want.bus)
                        report_mismatch("bus_byte", got.bus, want.bus);
                    if (got.fault !== want.fault)
                        report_mismatch("fault_out", got.fault, want.fault);
                end
            end
            // sample transaction
            if (s_valid && s_ready)
                step_supervisor(s_switch_forward, s_switch_reverse, s_pot_code,
                                s_current_a_code, s_current_b_code, s_current_c_code,
                                s_ack_level);
            pending_count <= line_states_due.size();
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import iss_pkg::*;

    typedef struct packed {
        logic  fwd;
        logic  rev;
        code_t pot;
        code_t ia;
        code_t ib;
        code_t ic;
        logic  ack;
    } tick_t;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_TOGGLE
    } sink_mode_t;

    logic                  aclk;
    logic                  aresetn          = 1'b0;
    logic                  s_valid          = 1'b0;
    logic                  s_ready;
    logic                  s_switch_forward = 1'b0;
    logic                  s_switch_reverse = 1'b0;
    code_t                 s_pot_code       = '0;
    code_t                 s_current_a_code = '0;
    code_t                 s_current_b_code = '0;
    code_t                 s_current_c_code = '0;
    logic                  s_ack_level      = 1'b0;
    logic                  m_valid;
    logic                  m_ready          = 1'b0;
    logic                  m_direction_out;
    logic                  m_ready_out;
    logic [BUS_W-1:0]      m_bus_byte;
    logic                  m_fault_out;
    logic                  cfg_valid        = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index        = '0;
    logic [CFG_DATA_W-1:0] cfg_data         = '0;

    int   error_count;
    int   pending_count;
    logic long_hold_req = 1'b0;

    // Sender burst state and running input levels
    int    burst_left = 0;
    bit    no_gaps    = 1'b0;
    logic  ack_now    = 1'b0;
    code_t last_pot   = '0;

    inverter_setpoint_supervisor_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_switch_forward (s_switch_forward),
        .s_switch_reverse (s_switch_reverse),
        .s_pot_code       (s_pot_code),
        .s_current_a_code (s_current_a_code),
        .s_current_b_code (s_current_b_code),
        .s_current_c_code (s_current_c_code),
        .s_ack_level      (s_ack_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_direction_out  (m_direction_out),
        .m_ready_out      (m_ready_out),
        .m_bus_byte       (m_bus_byte),
        .m_fault_out      (m_fault_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    setpoint_checker setpoint_chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_switch_forward (s_switch_forward),
        .s_switch_reverse (s_switch_reverse),
        .s_pot_code       (s_pot_code),
        .s_current_a_code (s_current_a_code),
        .s_current_b_code (s_current_b_code),
        .s_current_c_code (s_current_c_code),
        .s_ack_level      (s_ack_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_direction_out  (m_direction_out),
        .m_ready_out      (m_ready_out),
        .m_bus_byte       (m_bus_byte),
        .m_fault_out      (m_fault_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .error_count      (error_count),
        .pending_count    (pending_count)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop
    initial begin : watchdog
        #5000000;
        $display("tb: done, errors");
        $finish;
    end

    // Result side: stall pattern changes every so often, plus one long hold-off
    initial begin : result_sink
        int         span;
        sink_mode_t mode;
        bit         held;
        span = 0;
        mode = SINK_OPEN;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (150) @(posedge aclk);
            end else begin
                if (span == 0) begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    SINK_OPEN:   m_ready <= 1'b1;
                    SINK_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:     m_ready <= ~m_ready;
                endcase
            end
        end
    end

    function automatic tick_t make_tick(input logic fwd, input logic rev, input int pot,
                                        input int ia, input int ib, input int ic,
                                        input logic ack);
        return '{fwd, rev, code_t'(pot), code_t'(ia), code_t'(ib), code_t'(ic), ack};
    endfunction

    // Mostly a switch closed; pot often repeated or nudged to hit the deadband;
    // ACK flips now and then so handshakes last a few ticks
    function automatic tick_t random_tick(input int unsigned max_i);
        tick_t       t;
        int unsigned sw;
        int unsigned pick;
        sw    = $urandom_range(0, 9);
        t.fwd = (sw >= 1 && sw <= 4) || sw >= 8;
        t.rev = sw >= 5;
        pick  = $urandom_range(0, 9);
        if (pick < 6)
            t.pot = code_t'($urandom_range(0, 1023));
        else if (pick < 8)
            t.pot = last_pot;
        else if (pick == 8)
            t.pot = code_t'(last_pot + $urandom_range(0, 6) - 3);
        else
            t.pot = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        last_pot = t.pot;
        t.ia = code_t'($urandom_range(0, max_i));
        t.ib = code_t'($urandom_range(0, max_i));
        t.ic = code_t'($urandom_range(0, max_i));
        if ($urandom_range(0, 3) == 0)
            ack_now = ~ack_now;
        t.ack = ack_now;
        return t;
    endfunction

    // One sample transaction, with burst gaps in front of it
    task automatic send_tick(input tick_t t);
        int gap;
        if (burst_left == 0 && !no_gaps) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 12);
        end else if (burst_left != 0) begin
            burst_left--;
        end
        s_valid          <= 1'b1;
        s_switch_forward <= t.fwd;
        s_switch_reverse <= t.rev;
        s_pot_code       <= t.pot;
        s_current_a_code <= t.ia;
        s_current_b_code <= t.ib;
        s_current_c_code <= t.ic;
        s_ack_level      <= t.ack;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_random(input int n, input int unsigned max_i);
        repeat (n) send_tick(random_tick(max_i));
    endtask

    // Stop offering and let every due result come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // All four registers with junk in the unused upper bits, then a stray index
    task automatic program_regs(input int unsigned fs, input int unsigned mn,
                                input int unsigned db, input int unsigned trip);
        write_reg(REG_FULL_SCALE, {1'($urandom_range(0, 1)), 15'(fs)});
        write_reg(REG_MIN_VOLT,   {1'($urandom_range(0, 1)), 15'(mn)});
        write_reg(REG_DEADBAND,   {1'($urandom_range(0, 1)), 15'(db)});
        write_reg(REG_TRIP,       {6'($urandom), 10'(trip)});
        write_reg(cfg_idx_t'($urandom_range(4, 255)), 16'($urandom));
        cfg_valid <= 1'b0;
        repeat (4) @(posedge aclk);
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        int          waited;
        int unsigned trip_mid;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (3) @(posedge aclk);

        // Reset settings: full pot, minimum clamp, no switch, both switches,
        // changes under and over the deadband, default trip with full currents
        send_tick(make_tick(1, 0, 1023, 1023, 1023, 1023, 0));
        send_tick(make_tick(1, 0, 1023, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 0, 0, 0, 0, 1));
        send_tick(make_tick(0, 1, 0, 1023, 1023, 1023, 1));
        send_tick(make_tick(0, 0, 500, 0, 0, 0, 0));
        send_tick(make_tick(0, 0, 500, 0, 0, 0, 0));
        send_tick(make_tick(1, 1, 0, 0, 0, 0, 1));
        send_tick(make_tick(1, 1, 0, 0, 0, 0, 1));
        send_tick(make_tick(1, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(1, 0, 17, 0, 0, 0, 0));
        send_tick(make_tick(1, 0, 25, 0, 0, 0, 1));
        send_tick(make_tick(1, 0, 26, 0, 0, 0, 1));
        send_tick(make_tick(0, 1, 1023, 1023, 0, 0, 1));
        send_tick(make_tick(0, 1, 1023, 0, 1023, 0, 0));
        send_tick(make_tick(1, 0, 682, 0, 0, 1023, 0));
        ack_now = 1'b0;

        // Long result hold-off while samples keep coming back to back
        long_hold_req <= 1'b1;
        no_gaps = 1'b1;
        run_random(40, 1023);
        no_gaps = 1'b0;
        run_random(345, 1023);

        // Full scale of 20000, no floor, zero deadband: unchanged setpoints
        drain_results();
        program_regs(20000, 0, 0, 1023);
        send_tick(make_tick(1, 0, 300, 0, 0, 0, ack_now));
        send_tick(make_tick(1, 0, 300, 0, 0, 0, ~ack_now));
        send_tick(make_tick(1, 0, 300, 0, 0, 0, ~ack_now));
        send_tick(make_tick(1, 0, 300, 0, 0, 0, ack_now));
        run_random(300, 1023);

        // Tiny full scale, floor and deadband of 20000
        drain_results();
        program_regs(1, 20000, 20000, 1023);
        run_random(200, 1023);

        // Full scale past the bus range: byte saturates
        drain_results();
        program_regs(32767, 0, 50, 1023);
        send_tick(make_tick(1, 0, 1023, 0, 0, 0, ack_now));
        send_tick(make_tick(1, 0, 800, 0, 0, 0, ~ack_now));
        send_tick(make_tick(0, 1, 800, 0, 0, 0, ~ack_now));
        send_tick(make_tick(0, 1, 1023, 0, 0, 0, ack_now));
        run_random(300, 1023);

        // Random settings with a live trip level, currents held at or below it
        repeat (2) begin
            drain_results();
            trip_mid = $urandom_range(600, 1000);
            program_regs($urandom_range(1, 20000), $urandom_range(0, 3000),
                         $urandom_range(0, 2000), trip_mid);
            run_random(350, trip_mid);
        end

        // Trip at zero: quiet currents first, then any current latches the fault
        drain_results();
        program_regs(12000, 200, 100, 0);
        run_random(30, 0);
        run_random(40, 1023);

        // Wind down
        s_valid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (pending_count != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (pending_count != 0)
            $display("tb: %0d results never arrived", pending_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
